### sv/ntaf_pkg.sv
// Shared types and constants for the number-to-ASCII formatter.
// No dependencies; imported by number_to_ascii_formatter and its bench.
`default_nettype none

package ntaf_pkg;

   // ASCII codes
   localparam logic [6:0] ZERO_CHAR     = 7'h30;
   localparam logic [6:0] X_CHAR        = 7'h78;
   localparam logic [6:0] HEX_BASE_HIGH = 7'h57;   // 'a' - 10
   localparam logic [3:0] NINE          = 4'd9;

   // Format kinds
   localparam logic KIND_HEX = 1'b0;
   localparam logic KIND_DEC = 1'b1;

   // Input item
   typedef struct packed {
      logic [63:0] value;
      logic        kind;
   } req_type;

   // Result item
   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } rsp_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PRE0 = 6'b000010,
      ST_PREX = 6'b000100,
      ST_HEX  = 6'b001000,
      ST_CONV = 6'b010000,
      ST_DEC  = 6'b100000
   } state_type;

   // Lowercase hex digit to ASCII
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      if (nib > NINE) begin
         return 7'(nib) + HEX_BASE_HIGH;
      end else begin
         return 7'(nib) + ZERO_CHAR;
      end
   endfunction

endpackage

`default_nettype wire

### sv/number_to_ascii_formatter.sv
// Number to ASCII formatter: top level with the conversion sequencer.
// Uses ntaf_pkg and ntaf_bcd_step.
//
// One number is taken when start is high and busy is low; busy then stays
// high until its last character has been issued. Characters come out one per
// cycle on rsp_valid with no way to hold them off, so the receiver must take
// every one. Hex: '0', 'x' and (VALUE_BITS+3)/4 digits, one per cycle.
// Decimal: a shift-and-add-3 unit runs once per bit of the hex-padded value,
// then the digit row is scanned from the top, one digit a cycle, skipping
// leading zeros without output.
`default_nettype none

module number_to_ascii_formatter #(
   parameter int VALUE_BITS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire ntaf_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output ntaf_pkg::rsp_type     rsp_data
);

   import ntaf_pkg::*;

   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int HEX_W      = HEX_DIGITS * 4;
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int ITER_W     = $clog2(HEX_W);
   localparam int DIG_W      = $clog2(DEC_DIGITS);

   state_type                  state_ff,   state_in;
   logic [HEX_W-1:0]           shift_ff,   shift_in;
   logic [DEC_DIGITS-1:0][3:0] bcd_ff,     bcd_in;
   logic [ITER_W-1:0]          iter_ff,    iter_in;
   logic [DIG_W-1:0]           idx_ff,     idx_in;
   logic                       started_ff, started_in;
   logic                       valid_ff,   valid_in;
   rsp_type                    data_ff,    data_in;

   logic [DEC_DIGITS-1:0][3:0] bcd_step;
   logic [3:0]                 dec_digit;

   // Binary to BCD step, used in the conversion state
   ntaf_bcd_step #(
      .DIGITS (DEC_DIGITS)
   ) u_bcd_step (
      .bcd_cur (bcd_ff),
      .bit_in  (shift_ff[HEX_W-1]),
      .bcd_nxt (bcd_step)
   );

   assign dec_digit = bcd_ff[idx_ff];

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      shift_in   = shift_ff;
      bcd_in     = bcd_ff;
      iter_in    = iter_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      valid_in   = 1'b0;
      data_in    = data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               shift_in = HEX_W'(req_data.value[VALUE_BITS-1:0]);
               if (req_data.kind == KIND_HEX) begin
                  idx_in   = DIG_W'(HEX_DIGITS - 1);
                  state_in = ST_PRE0;
               end else begin
                  bcd_in   = '0;
                  iter_in  = ITER_W'(HEX_W - 1);
                  state_in = ST_CONV;
               end
            end
         end
         ST_PRE0: begin
            valid_in  = 1'b1;
            data_in   = '{character: ZERO_CHAR, last: 1'b0};
            state_in  = ST_PREX;
         end
         ST_PREX: begin
            valid_in  = 1'b1;
            data_in   = '{character: X_CHAR, last: 1'b0};
            state_in  = ST_HEX;
         end
         ST_HEX: begin
            // top nibble out, most significant first
            valid_in  = 1'b1;
            data_in   = '{character: hex_char(shift_ff[HEX_W-1 -: 4]),
                          last: (idx_ff == '0)};
            shift_in  = {shift_ff[HEX_W-5:0], 4'b0000};
            idx_in    = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_CONV: begin
            bcd_in   = bcd_step;
            shift_in = {shift_ff[HEX_W-2:0], 1'b0};
            iter_in  = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               idx_in     = DIG_W'(DEC_DIGITS - 1);
               started_in = 1'b0;
               state_in   = ST_DEC;
            end
         end
         ST_DEC: begin
            // leading zeros are passed over, the units digit always goes out
            idx_in = idx_ff - 1'b1;
            if (started_ff || dec_digit != 4'd0 || idx_ff == '0) begin
               valid_in   = 1'b1;
               data_in    = '{character: ZERO_CHAR + 7'(dec_digit),
                              last: (idx_ff == '0)};
               started_in = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         started_ff <= 1'b0;
         iter_ff    <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         started_ff <= started_in;
         iter_ff    <= iter_in;
         idx_ff     <= idx_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      data_ff  <= data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### sv/ntaf_bcd_step.sv
// One shift-and-add-3 step of binary to BCD conversion over a row of digits.
// Depends on nothing beyond its parameter; used by number_to_ascii_formatter.
`default_nettype none

module ntaf_bcd_step #(
   parameter int DIGITS = 20
) (
   input  wire logic [DIGITS-1:0][3:0] bcd_cur,
   input  wire logic                   bit_in,
   output logic      [DIGITS-1:0][3:0] bcd_nxt
);

   logic [DIGITS-1:0][3:0] adj;
   logic [DIGITS*4-1:0]    adj_row;

   // Correct every digit of five or more, then shift the row left by one bit
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adj[d] = (bcd_cur[d] >= 4'd5) ? bcd_cur[d] + 4'd3 : bcd_cur[d];
      end
      adj_row = adj;
      bcd_nxt = {adj_row[DIGITS*4-2:0], bit_in};
   end

endmodule

`default_nettype wire

### bench/number_to_ascii_formatter_tb.sv
// Self-checking bench for number_to_ascii_formatter: hex and decimal formatting.
// Depends on ntaf_pkg (item types, ASCII codes, kind codes) and the formatter RTL.
`timescale 1ns / 1ps

module number_to_ascii_formatter_tb;
   import ntaf_pkg::*;

   localparam int VALUE_BITS  = 64;
   localparam int HEX_DIGITS  = (VALUE_BITS + 3) / 4;
   localparam int ROW_DEPTH   = 20;
   localparam int DEC_RADIX   = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 120;   // extra idle time after the final drain
   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam logic [63:0] MAX_VALUE  = {64{1'b1}};

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predictor state
   logic [63:0] work_value;
   logic [3:0]  digit_row [ROW_DEPTH];
   int          digit_total;

   rsp_type expected_chars [$];
   int      sender_idle_pct;
   int      error_count;
   int      chars_checked;
   int      hex_items;
   int      dec_items;
   int      cycle_count;

   number_to_ascii_formatter #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Clock, 4 ns period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      error_count = 0;
      cycle_count = 0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // Work out the character run that one number produces
   task automatic predict_characters(input req_type item);
      logic [63:0] rest;
      rsp_type     ch;
      int          k;
      work_value = item.value & VALUE_MASK;
      if (item.kind == KIND_HEX) begin
         for (k = 0; k < HEX_DIGITS; k++) begin
            digit_row[k] = work_value[4*k +: 4];
         end
         digit_total = HEX_DIGITS;
         ch.last = 1'b0;
         ch.character = ZERO_CHAR;
         expected_chars.push_back(ch);
         ch.character = X_CHAR;
         expected_chars.push_back(ch);
      end else begin
         rest = work_value;
         digit_total = 0;
         if (rest == 0) begin
            digit_row[0] = 4'd0;
            digit_total = 1;
         end
         while (rest != 0 && digit_total < ROW_DEPTH) begin
            digit_row[digit_total] = 4'(rest % DEC_RADIX);
            digit_total++;
            rest = rest / DEC_RADIX;
         end
      end
      // most significant digit first; letters only occur in hex
      for (k = digit_total - 1; k >= 0; k--) begin
         ch.character = 7'(digit_row[k]) + ((digit_row[k] > NINE) ? HEX_BASE_HIGH : ZERO_CHAR);
         ch.last = (k == 0);
         expected_chars.push_back(ch);
      end
   endtask

   // Offer one number; returns once it has been taken and start is dropped
   task automatic send_number(input logic [63:0] value, input logic kind);
      req_type item;
      item.value = value;
      item.kind  = kind;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predict_characters(item);
      if (kind == KIND_HEX) hex_items++;
      else dec_items++;
      // busy is still high when start is dropped here, so the number cannot be taken twice
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // Random value with a spread of magnitudes and decimal boundaries
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      logic [63:0] p;
      int          n;
      case ($urandom_range(0, 5))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         2: begin
            p = 64'd1;
            n = $urandom_range(0, 19);
            repeat (n) p = p * DEC_RADIX;
            case ($urandom_range(0, 2))
               0: v = p - 1;
               1: v = p;
               default: v = p + 1;
            endcase
         end
         3: v = 64'($urandom_range(0, 25));
         4: v = MAX_VALUE - 64'($urandom_range(0, 3));
         default: v = {$urandom, $urandom} & ({$urandom, $urandom} | {$urandom, $urandom});
      endcase
      return v;
   endfunction

   // Hex: leading zeros kept, every nibble value, both ends of the range
   task automatic test_hex_format();
      send_number(64'h0, KIND_HEX);
      send_number(MAX_VALUE, KIND_HEX);
      send_number(64'h0123_4567_89ab_cdef, KIND_HEX);
      send_number(64'hfedc_ba98_7654_3210, KIND_HEX);
      send_number(64'haaaa_aaaa_aaaa_aaaa, KIND_HEX);
      send_number(64'h5555_5555_5555_5555, KIND_HEX);
      send_number(64'h8000_0000_0000_0000, KIND_HEX);
      send_number(64'h1, KIND_HEX);
      wait_for_drain();
   endtask

   // Decimal: zero as a single digit, digit-count boundaries, full 20 digits
   task automatic test_decimal_format();
      send_number(64'd0, KIND_DEC);
      send_number(64'd1, KIND_DEC);
      send_number(64'd9, KIND_DEC);
      send_number(64'd10, KIND_DEC);
      send_number(64'd99, KIND_DEC);
      send_number(64'd100, KIND_DEC);
      send_number(64'd1234567890, KIND_DEC);
      send_number(64'd9999999999999999999, KIND_DEC);
      send_number(64'd10000000000000000000, KIND_DEC);
      send_number(64'h8000_0000_0000_0000, KIND_DEC);
      send_number(64'h5555_5555_5555_5555, KIND_DEC);
      send_number(MAX_VALUE, KIND_DEC);
      send_number(64'd0, KIND_DEC);
      wait_for_drain();
   endtask

   task automatic test_random_numbers(input int count, input int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (count) send_number(random_value(), 1'($urandom_range(0, 1)));
      sender_idle_pct = 0;
      wait_for_drain();
   endtask

   // Check each character against the oldest expectation
   always @(posedge clock) begin : check_characters
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                      rsp_data.character, rsp_data.last));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_data.character !== want.character)
               report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                         rsp_data.character, want.character));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b on 0x%02h, wanted %0b",
                                         rsp_data.last, want.character, want.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles, %0d characters outstanding",
                  cycle_count, expected_chars.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      sender_idle_pct = 0;
      chars_checked   = 0;
      hex_items       = 0;
      dec_items       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hex_format();
      test_decimal_format();
      test_random_numbers(97, 0);
      test_random_numbers(97, 51);
      test_random_numbers(97, 0);
      test_random_numbers(97, 34);

      @(negedge clock);
      start <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("formatted %0d numbers (%0d hex, %0d decimal), %0d characters compared",
               hex_items + dec_items, hex_items, dec_items, chars_checked);
      $display("sender gaps at 0, 51 and 34 per cent, %0d mismatches", error_count);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
sv/ntaf_pkg.sv
sv/ntaf_bcd_step.sv
sv/number_to_ascii_formatter.sv
bench/number_to_ascii_formatter_tb.sv
